>>> design/isort_pkg.sv
// shared types for the insertion sorter: controller states, command and status bundles
package isort_pkg;

  // controller states, one-hot
  typedef enum logic [1:0] {
    ST_LOAD  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic insert;     // take the incoming key into the store
    logic shift_out;  // head item taken, shift store toward the head
    logic clear;      // set is finished, clear the drop flag
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic last_one;   // store holds exactly one key
  } status_t;

endpackage

>>> design/isort_datapath.sv
// compare-and-shift key store with count, drop flag and order register
module isort_datapath #(
  parameter int MAX_KEYS = 32,
  parameter int KEY_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic                       cfg_data,
  input  logic signed [KEY_BITS-1:0] key_in,
  input  isort_pkg::cmd_t            cmd,
  output isort_pkg::status_t         status,
  output logic signed [KEY_BITS-1:0] key_out,
  output logic                       overflow
);
  import isort_pkg::*;

  localparam int CNT_W = $clog2(MAX_KEYS + 1);

  logic signed [KEY_BITS-1:0] cells [MAX_KEYS];
  logic [CNT_W-1:0]           count;
  logic                       dropped;
  logic                       descending;
  logic                       full;
  logic [MAX_KEYS-1:0]        gt;

  assign full = (count == CNT_W'(MAX_KEYS));

  // per-cell compare: stored key moves behind the new key
  always_comb begin
    for (int i = 0; i < MAX_KEYS; i++) begin
      gt[i] = (CNT_W'(i) < count) &&
              (descending ? (cells[i] < key_in) : (cells[i] > key_in));
    end
  end

  // one cell of the store per position
  for (genvar g = 0; g < MAX_KEYS; g++) begin : g_cell
    logic                       prev_gt;
    logic signed [KEY_BITS-1:0] prev_key;
    logic signed [KEY_BITS-1:0] shift_key;
    logic                       wr_en;

    if (g == 0) begin : g_head
      assign prev_gt  = 1'b0;
      assign prev_key = key_in;
    end else begin : g_body
      assign prev_gt  = gt[g-1];
      assign prev_key = cells[g-1];
    end

    if (g == MAX_KEYS - 1) begin : g_tail
      assign shift_key = cells[g];
    end else begin : g_mid
      assign shift_key = cells[g+1];
    end

    // write when a key moves in from the left or the new key lands here
    assign wr_en = (CNT_W'(g) <= count) && (prev_gt || gt[g] || (CNT_W'(g) == count));

    always_ff @(posedge clk) begin
      if (cmd.insert && !full && wr_en) begin
        cells[g] <= prev_gt ? prev_key : key_in;
      end else if (cmd.shift_out) begin
        cells[g] <= shift_key;
      end
    end
  end

  // key count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.insert && !full) begin
      count <= count + CNT_W'(1);
    end else if (cmd.shift_out) begin
      count <= count - CNT_W'(1);
    end
  end

  // drop flag
  always_ff @(posedge clk) begin
    if (rst) begin
      dropped <= 1'b0;
    end else if (cmd.clear) begin
      dropped <= 1'b0;
    end else if (cmd.insert && full) begin
      dropped <= 1'b1;
    end
  end

  // sort order register
  always_ff @(posedge clk) begin
    if (rst) begin
      descending <= 1'b0;
    end else if (cfg_write) begin
      descending <= cfg_data;
    end
  end

  assign status.last_one = (count == CNT_W'(1));
  assign key_out         = cells[0];
  assign overflow        = dropped;

endmodule

>>> design/isort_ctrl.sv
// controller: load keys until the closing item, then drain the sorted set
module isort_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_last,
  input  isort_pkg::status_t status,
  output isort_pkg::cmd_t    cmd
);
  import isort_pkg::*;

  state_t state;
  state_t state_next;

  // handshake and commands
  always_comb begin
    in_ready      = (state == ST_LOAD);
    out_valid     = (state == ST_DRAIN);
    out_last      = (state == ST_DRAIN) && status.last_one;
    cmd.insert    = in_ready && in_valid;
    cmd.shift_out = out_valid && out_ready;
    cmd.clear     = cmd.shift_out && status.last_one;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (in_valid && in_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_ready && status.last_one) begin
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> design/insertion_sorter_core.sv
// insertion sorter top level: one key inserted per cycle while loading, sorted set emitted one
// item per cycle while out_ready is high; a key is taken every cycle while loading; a parallel
// compare in every store cell places it; the set drains from the head cell, the first item in
// the cycle after the closing key is taken; no input is taken while a set drains
// synchronous reset empties the store, clears the drop flag and selects ascending order
module insertion_sorter_core #(
  parameter int MAX_KEYS = 32,
  parameter int KEY_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic                       cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [KEY_BITS-1:0] key_in,
  input  logic                       in_last,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [KEY_BITS-1:0] key_out,
  output logic                       out_last,
  output logic                       overflow
);
  import isort_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencing
  isort_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_last  (out_last),
    .status    (status),
    .cmd       (cmd)
  );

  // key store
  isort_datapath #(
    .MAX_KEYS (MAX_KEYS),
    .KEY_BITS (KEY_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .key_in    (key_in),
    .cmd       (cmd),
    .status    (status),
    .key_out   (key_out),
    .overflow  (overflow)
  );

endmodule
